FILE: design/frar_pkg.sv
// Shared constants and types of the frame receive and acknowledge router.
package frar_pkg;

	localparam int LEN_W  = 10;
	localparam int SEQ_W  = 7;
	localparam int ADDR_W = 8;
	localparam int CNT_W  = 8;
	localparam int KIND_W = 2;
	localparam int IDX_W  = 3;
	localparam int CFG_W  = 10;

	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 16;

	localparam logic [LEN_W-1:0] MAX_FRAME_LEN = 10'd1023;

	localparam logic [KIND_W-1:0] KIND_ACK  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_NACK = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SACK = 2'd2;

	localparam logic [IDX_W-1:0] REG_MACHINE_ID     = 3'd0;
	localparam logic [IDX_W-1:0] REG_BROADCAST_ADDR = 3'd1;
	localparam logic [IDX_W-1:0] REG_MIN_LEN        = 3'd2;
	localparam logic [IDX_W-1:0] REG_MAX_SEQ        = 3'd3;
	localparam logic [IDX_W-1:0] REG_FAIL_LIMIT     = 3'd4;

	typedef struct packed {
		logic [ADDR_W-1:0] src_addr;
		logic [ADDR_W-1:0] dest_addr;
		logic [SEQ_W-1:0]  rx_seq;
		logic [LEN_W-1:0]  hdr_len;
		logic [LEN_W-1:0]  rx_len;
	} frame_hdr_t;

	typedef struct packed {
		logic [SEQ_W-1:0]  reply_seq;
		logic [KIND_W-1:0] reply_kind;
		logic              undeliverable;
		logic              forward_out;
		logic              deliver_local;
	} reply_t;

endpackage

FILE: design/frame_receive_ack_router.sv
// Receiver of a ring link: checks frame headers, routes good frames and builds the reply.
//
// One frame header is taken per clock cycle and its reply is built through a header register,
// one pass of compare logic that also updates the expected sequence and mismatch counter,
// then a result register. The result register lets the next header enter while a reply
// waits on m_tready; the only pause comes from the downstream side. Configuration
// registers are written through cfg_we/cfg_index/cfg_wdata; the user must write them only
// while no request is in flight, as the block itself does not enforce it.
module frame_receive_ack_router
	import frar_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// rx_len[9:0], hdr_len[19:10], rx_seq[26:20], dest_addr[34:27], src_addr[42:35], zero pad
	input  logic [IN_DATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// deliver_local[0], forward_out[1], undeliverable[2], reply_seq[9:3], zero pad
	output logic [OUT_DATA_W-1:0] m_tdata,
	// reply_kind[1:0]
	output logic [KIND_W-1:0]     m_tuser,
	input  logic                  cfg_we,
	input  logic [IDX_W-1:0]      cfg_index,
	input  logic [CFG_W-1:0]      cfg_wdata
);

	logic [ADDR_W-1:0] machine_id_q;
	logic [ADDR_W-1:0] broadcast_addr_q;
	logic [LEN_W-1:0]  min_len_q;
	logic [SEQ_W-1:0]  max_seq_q;
	logic [CNT_W-1:0]  fail_limit_q;

	logic [SEQ_W-1:0]  expected_seq_q;
	logic [CNT_W-1:0]  mismatch_count_q;

	logic              valid_s1;
	frame_hdr_t        hdr_s1;
	logic              valid_s2;
	reply_t            reply_s2;

	logic              adv_s1;
	reply_t            reply_d;
	logic [SEQ_W-1:0]  expected_seq_d;
	logic [CNT_W-1:0]  mismatch_count_d;
	logic [LEN_W-1:0]  len_capped;
	logic [CNT_W-1:0]  count_inc;
	logic [SEQ_W:0]    seq_inc;

	assign adv_s1   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	always_comb begin
		len_capped       = (hdr_s1.rx_len > MAX_FRAME_LEN) ? MAX_FRAME_LEN : hdr_s1.rx_len;
		count_inc        = (mismatch_count_q == {CNT_W{1'b1}}) ? mismatch_count_q
		                   : mismatch_count_q + 1'b1;
		seq_inc          = {1'b0, expected_seq_q} + 1'b1;
		reply_d          = '0;
		expected_seq_d   = expected_seq_q;
		mismatch_count_d = mismatch_count_q;
		priority if (len_capped < min_len_q || len_capped != hdr_s1.hdr_len) begin
			reply_d.reply_kind = KIND_NACK;
			reply_d.reply_seq  = expected_seq_q;
		end else if (hdr_s1.rx_seq != expected_seq_q) begin
			if (count_inc >= fail_limit_q) begin
				expected_seq_d     = '0;
				mismatch_count_d   = '0;
				reply_d.reply_kind = KIND_SACK;
			end else begin
				mismatch_count_d   = count_inc;
				reply_d.reply_kind = KIND_NACK;
			end
		end else begin
			priority if (hdr_s1.dest_addr == broadcast_addr_q) begin
				reply_d.deliver_local = 1'b1;
				reply_d.forward_out   = (hdr_s1.src_addr != machine_id_q);
			end else if (hdr_s1.dest_addr == machine_id_q) begin
				reply_d.deliver_local = 1'b1;
			end else if (hdr_s1.src_addr == machine_id_q) begin
				reply_d.undeliverable = 1'b1;
			end else begin
				reply_d.forward_out = 1'b1;
			end
			mismatch_count_d   = '0;
			expected_seq_d     = (seq_inc > {1'b0, max_seq_q}) ? '0 : seq_inc[SEQ_W-1:0];
			reply_d.reply_kind = KIND_ACK;
			reply_d.reply_seq  = expected_seq_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			machine_id_q     <= '0;
			broadcast_addr_q <= 8'd255;
			min_len_q        <= 10'd4;
			max_seq_q        <= 7'd7;
			fail_limit_q     <= 8'd3;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MACHINE_ID:     machine_id_q     <= cfg_wdata[ADDR_W-1:0];
				REG_BROADCAST_ADDR: broadcast_addr_q <= cfg_wdata[ADDR_W-1:0];
				REG_MIN_LEN:        min_len_q        <= cfg_wdata[LEN_W-1:0];
				REG_MAX_SEQ:        max_seq_q        <= cfg_wdata[SEQ_W-1:0];
				REG_FAIL_LIMIT:     fail_limit_q     <= cfg_wdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_seq_q   <= '0;
			mismatch_count_q <= '0;
		end else if (adv_s1) begin
			expected_seq_q   <= expected_seq_d;
			mismatch_count_q <= mismatch_count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			hdr_s1 <= s_tdata[$bits(frame_hdr_t)-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			reply_s2 <= reply_d;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = reply_s2.reply_kind;
	assign m_tdata  = {{(OUT_DATA_W - SEQ_W - 3){1'b0}}, reply_s2.reply_seq,
	                   reply_s2.undeliverable, reply_s2.forward_out, reply_s2.deliver_local};

endmodule

FILE: design/frar_checker.sv
// Port-level checker of the frame receive and acknowledge router, with its bind.
module frar_checker
	import frar_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic [KIND_W-1:0]     m_tuser
);

	a_hold_reply: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("reply changed while stalled");

	a_sack_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_SACK |-> m_tdata == '0)
		else $error("restart ack carries routing or sequence");

	a_nack_no_route: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_NACK |-> m_tdata[2:0] == 3'b000)
		else $error("nack carries routing");

	a_undeliv_alone: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2] |-> m_tdata[1:0] == 2'b00 && m_tuser == KIND_ACK)
		else $error("undeliverable frame mixed with delivery");

endmodule

bind frame_receive_ack_router frar_checker u_frar_checker (.*);

FILE: bench/tb_frame_receive_ack_router.sv
// Testbench for the ring-link frame receiver: directed and random headers checked against a predictor.
`timescale 1ns / 1ps

module tb_frame_receive_ack_router;
	import frar_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	// rx_len[9:0], hdr_len[19:10], rx_seq[26:20], dest_addr[34:27], src_addr[42:35], zero pad
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	// deliver_local[0], forward_out[1], undeliverable[2], reply_seq[9:3], zero pad
	logic [OUT_DATA_W-1:0] m_tdata;
	// reply_kind[1:0]
	logic [KIND_W-1:0]     m_tuser;
	logic                  cfg_we;
	logic [IDX_W-1:0]      cfg_index;
	logic [CFG_W-1:0]      cfg_wdata;

	frame_receive_ack_router dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	logic [ADDR_W-1:0] cfg_machine;
	logic [ADDR_W-1:0] cfg_bcast;
	logic [LEN_W-1:0]  cfg_min_len;
	logic [SEQ_W-1:0]  cfg_max_seq;
	logic [CNT_W-1:0]  cfg_fail_limit;

	logic [SEQ_W-1:0]  cur_seq;
	logic [CNT_W-1:0]  miss_cnt;

	reply_t pending_replies[$];
	int     fail_count;
	bit     steady_flow;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3ms;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic reply_t route_and_ack(frame_hdr_t f);
		reply_t           r;
		logic [LEN_W-1:0] len;
		r = '0;
		len = f.rx_len;
		if (len > MAX_FRAME_LEN)
			len = MAX_FRAME_LEN;
		if (len < cfg_min_len || len != f.hdr_len) begin
			r.reply_kind = KIND_NACK;
			r.reply_seq = cur_seq;
		end else if (f.rx_seq != cur_seq) begin
			if (miss_cnt != 8'hFF)
				miss_cnt = miss_cnt + 8'd1;
			if (miss_cnt >= cfg_fail_limit) begin
				cur_seq = '0;
				miss_cnt = '0;
				r.reply_kind = KIND_SACK;
			end else begin
				r.reply_kind = KIND_NACK;
			end
			r.reply_seq = '0;
		end else begin
			if (f.dest_addr == cfg_bcast) begin
				r.deliver_local = 1'b1;
				r.forward_out = (f.src_addr != cfg_machine);
			end else if (f.dest_addr == cfg_machine) begin
				r.deliver_local = 1'b1;
			end else if (f.src_addr == cfg_machine) begin
				r.undeliverable = 1'b1;
			end else begin
				r.forward_out = 1'b1;
			end
			miss_cnt = '0;
			if (cur_seq >= cfg_max_seq)
				cur_seq = '0;
			else
				cur_seq = cur_seq + 7'd1;
			r.reply_kind = KIND_ACK;
			r.reply_seq = cur_seq;
		end
		return r;
	endfunction

	always @(posedge clk) begin
		reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_replies.size() == 0) begin
				$error("unexpected reply: tdata %h tuser %h", m_tdata, m_tuser);
				fail_count++;
			end else begin
				want = pending_replies.pop_front();
				if (m_tdata[0] !== want.deliver_local) begin
					$error("deliver_local: expected %0d, got %0d", want.deliver_local,
						m_tdata[0]);
					fail_count++;
				end
				if (m_tdata[1] !== want.forward_out) begin
					$error("forward_out: expected %0d, got %0d", want.forward_out, m_tdata[1]);
					fail_count++;
				end
				if (m_tdata[2] !== want.undeliverable) begin
					$error("undeliverable: expected %0d, got %0d", want.undeliverable,
						m_tdata[2]);
					fail_count++;
				end
				if (m_tuser !== want.reply_kind) begin
					$error("reply_kind: expected %0d, got %0d", want.reply_kind, m_tuser);
					fail_count++;
				end
				if (m_tdata[9:3] !== want.reply_seq) begin
					$error("reply_seq: expected %0d, got %0d", want.reply_seq, m_tdata[9:3]);
					fail_count++;
				end
			end
		end
		if (arst_n && s_tvalid && s_tready)
			pending_replies.push_back(route_and_ack(frame_hdr_t'(s_tdata[42:0])));
	end

	initial begin
		int stall;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = steady_flow ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	function automatic frame_hdr_t make_frame(int rx_len, int hdr_len, int seq, int dest,
			int src);
		frame_hdr_t f;
		f.rx_len = rx_len[LEN_W-1:0];
		f.hdr_len = hdr_len[LEN_W-1:0];
		f.rx_seq = seq[SEQ_W-1:0];
		f.dest_addr = dest[ADDR_W-1:0];
		f.src_addr = src[ADDR_W-1:0];
		return f;
	endfunction

	function automatic frame_hdr_t good_frame(int dest, int src);
		int len;
		len = $urandom_range(int'(cfg_min_len), 1023);
		return make_frame(len, len, cur_seq, dest, src);
	endfunction

	task automatic send_frame(frame_hdr_t f);
		int gap;
		gap = steady_flow ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_DATA_W - 43){1'b0}}, f};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		#0;
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, int val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val[CFG_W-1:0];
		case (idx)
			REG_MACHINE_ID:     cfg_machine = val[ADDR_W-1:0];
			REG_BROADCAST_ADDR: cfg_bcast = val[ADDR_W-1:0];
			REG_MIN_LEN:        cfg_min_len = val[LEN_W-1:0];
			REG_MAX_SEQ:        cfg_max_seq = val[SEQ_W-1:0];
			REG_FAIL_LIMIT:     cfg_fail_limit = val[CNT_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_all(int machine, int bcast, int min_len, int max_seq, int limit);
		drain();
		write_reg(REG_MACHINE_ID, machine);
		write_reg(REG_BROADCAST_ADDR, bcast);
		write_reg(REG_MIN_LEN, min_len);
		write_reg(REG_MAX_SEQ, max_seq);
		write_reg(REG_FAIL_LIMIT, limit);
	endtask

	task automatic test_length_checks;
		send_frame(make_frame(3, 3, cur_seq, 0, 1));
		send_frame(make_frame(1023, 1022, cur_seq, 0, 1));
		send_frame(make_frame(0, 0, cur_seq, 0, 1));
		send_frame(make_frame(1023, 1023, cur_seq, 0, 1));
		send_frame(make_frame(4, 4, cur_seq, 0, 1));
		drain();
	endtask

	task automatic test_routing;
		write_reg(REG_MACHINE_ID, 8'h5A);
		write_reg(REG_BROADCAST_ADDR, 8'hFF);
		send_frame(good_frame(8'hFF, 8'h11));
		send_frame(good_frame(8'hFF, 8'h5A));
		send_frame(good_frame(8'h5A, 8'h22));
		send_frame(good_frame(8'h33, 8'h5A));
		send_frame(good_frame(8'h00, 8'h44));
		drain();
		write_reg(REG_BROADCAST_ADDR, 8'h5A);
		send_frame(good_frame(8'h5A, 8'h66));
		send_frame(good_frame(8'h5A, 8'h5A));
		drain();
	endtask

	task automatic test_sequence_mismatch;
		write_reg(REG_FAIL_LIMIT, 3);
		repeat (3) send_frame(make_frame(16, 16, cur_seq + 7'd1, 8'h5A, 8'h01));
		drain();
		write_reg(REG_FAIL_LIMIT, 1);
		send_frame(make_frame(16, 16, cur_seq + 7'd3, 8'h5A, 8'h01));
		send_frame(good_frame(8'h5A, 8'h01));
		drain();
	endtask

	task automatic test_seq_wrap;
		write_reg(REG_MAX_SEQ, 2);
		repeat (4) send_frame(good_frame(8'h5A, 8'h02));
		drain();
		write_reg(REG_MAX_SEQ, 0);
		send_frame(good_frame(8'h5A, 8'h02));
		drain();
		write_reg(REG_MAX_SEQ, 127);
		send_frame(good_frame(8'h5A, 8'h02));
		drain();
	endtask

	task automatic random_item(int good_pct);
		int pick;
		int dest;
		int src;
		int len;
		int hdr;
		pick = $urandom_range(0, 99);
		case ($urandom_range(0, 3))
			0: dest = cfg_bcast;
			1: dest = cfg_machine;
			default: dest = $urandom_range(0, 255);
		endcase
		src = ($urandom_range(0, 1) == 1) ? int'(cfg_machine) : $urandom_range(0, 255);
		if (pick < good_pct) begin
			send_frame(good_frame(dest, src));
		end else if (pick < good_pct + (100 - good_pct) / 2) begin
			len = $urandom_range(int'(cfg_min_len), 1023);
			send_frame(make_frame(len, len, cur_seq + 7'($urandom_range(1, 127)), dest, src));
		end else if (pick < 96) begin
			if (cfg_min_len > 0 && $urandom_range(0, 1) == 1) begin
				len = $urandom_range(0, int'(cfg_min_len) - 1);
				hdr = len;
			end else begin
				len = $urandom_range(0, 1023);
				hdr = len ^ $urandom_range(1, 1023);
			end
			send_frame(make_frame(len, hdr, cur_seq, dest, src));
		end else begin
			send_frame(make_frame($urandom_range(0, 1023), $urandom_range(0, 1023),
				$urandom_range(0, 127), $urandom_range(0, 255), $urandom_range(0, 255)));
		end
	endtask

	task automatic test_random;
		int phase;
		int count;
		int good_pct;
		int machine;
		for (phase = 0; phase < 11; phase++) begin
			count = 150;
			good_pct = 70;
			case (phase)
				0: write_all(0, 255, 0, 127, 255);
				1: write_all(255, 0, 1023, 0, 1);
				2: write_all(255, 255, 4, 7, 3);
				3: begin
					write_all($urandom_range(0, 255), $urandom_range(0, 255), 0, 127, 255);
					good_pct = 5;
					count = 300;
				end
				default: begin
					machine = $urandom_range(0, 255);
					write_all(machine,
						($urandom_range(0, 3) == 0) ? machine : $urandom_range(0, 255),
						($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
							: $urandom_range(0, 64),
						$urandom_range(0, 127),
						($urandom_range(0, 1) == 0) ? $urandom_range(1, 255)
							: $urandom_range(1, 8));
				end
			endcase
			steady_flow = (phase % 4 == 1);
			repeat (count) random_item(good_pct);
		end
		steady_flow = 1'b0;
		drain();
	endtask

	initial begin
		fail_count = 0;
		steady_flow = 1'b0;
		cfg_machine = 8'd0;
		cfg_bcast = 8'd255;
		cfg_min_len = 10'd4;
		cfg_max_seq = 7'd7;
		cfg_fail_limit = 8'd3;
		cur_seq = '0;
		miss_cnt = '0;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_length_checks();
		test_routing();
		test_sequence_mismatch();
		test_seq_wrap();
		test_random();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending_replies.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

FILE: filelist.f
design/frar_pkg.sv
design/frame_receive_ack_router.sv
design/frar_checker.sv
bench/tb_frame_receive_ack_router.sv
